// ===== rtl/shd_pkg.sv =====
// shd_pkg: shared constants, request and phase codes, and the command/status
// structs that join the stroke hold controller and datapath.
// No dependencies.
package shd_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int AW          = $clog2(MAX_SAMPLES);
    localparam int CW          = $clog2(MAX_SAMPLES + 1);

    localparam int XW   = 16;
    localparam int TW   = 48;
    localparam int DW   = 16;
    localparam int HW   = 24;
    localparam int CFGW = 24;

    // request codes
    localparam logic [2:0] REQ_BEGIN     = 3'd0;
    localparam logic [2:0] REQ_APPEND    = 3'd1;
    localparam logic [2:0] REQ_REPLAY    = 3'd2;
    localparam logic [2:0] REQ_FINISH    = 3'd3;
    localparam logic [2:0] REQ_INTERRUPT = 3'd4;

    // stroke phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_CAPT   = 2'd1;
    localparam logic [1:0] PH_HELD   = 2'd2;
    localparam logic [1:0] PH_REPLAY = 2'd3;

    // configuration register indexes
    localparam logic REG_DRIFT_LIMIT = 1'b0;
    localparam logic REG_HOLD_US     = 1'b1;

    localparam logic [DW-1:0] DRIFT_RESET = 16'd32;
    localparam logic [HW-1:0] HOLD_RESET  = 24'd500000;

    typedef struct packed {
        logic clear;   // empty the ring
        logic store;   // write the incoming sample
        logic walk;    // start the stationary-run walk
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic held;
        logic trunc;
    } t_stat;

endpackage

// ===== rtl/stroke_hold_detector.sv =====
// stroke_hold_detector: top level, joins controller and datapath.
// Depends on shd_pkg, shd_ctrl, shd_datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  request   | i_start / o_busy       | i_req_type i_pos_x i_pos_y i_timestamp_us
//            |                        | i_interrupt_reason
//  result    | o_done (one cycle)     | o_accepted o_phase o_last_reason o_run_truncated
//  config    | i_cfg_we               | i_cfg_index i_cfg_wdata
//
// A request is taken when i_start is high and o_busy is low. Every request
// but an accepted append gives its result on o_done in the next cycle and
// never raises o_busy. An accepted append walks the ring, one memory read per
// cycle through a read/square/compare pipeline over the n retained older samples
// (255 at a full ring), stopping early on too large a drift; o_busy stays high
// until the cycle in which the result shows on o_done.
// Reset is synchronous and clears pointers and phase; ring contents are not
// cleared. The result receiver cannot stall.
module stroke_hold_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [2:0]                    i_req_type,
    input  logic signed [shd_pkg::XW-1:0] i_pos_x,
    input  logic signed [shd_pkg::XW-1:0] i_pos_y,
    input  logic [shd_pkg::TW-1:0]        i_timestamp_us,
    input  logic [2:0]                    i_interrupt_reason,
    output logic                          o_done,
    output logic                          o_accepted,
    output logic [1:0]                    o_phase,
    output logic [2:0]                    o_last_reason,
    output logic                          o_run_truncated,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [shd_pkg::CFGW-1:0]      i_cfg_wdata
);
    import shd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    shd_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .i_req_type         (i_req_type),
        .i_interrupt_reason (i_interrupt_reason),
        .i_stat             (stat),
        .o_cmd              (cmd),
        .o_busy             (o_busy),
        .o_done             (o_done),
        .o_accepted         (o_accepted),
        .o_phase            (o_phase),
        .o_last_reason      (o_last_reason),
        .o_run_truncated    (o_run_truncated)
    );

    shd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_timestamp_us (i_timestamp_us),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

// ===== rtl/shd_ctrl.sv =====
// shd_ctrl: request decoder and sequencer; owns the stroke phase, the
// recorded reason and the result registers. Depends on shd_pkg.
module shd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2:0]          i_req_type,
    input  logic [2:0]          i_interrupt_reason,
    input  shd_pkg::t_stat      i_stat,
    output shd_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_done,
    output logic                o_accepted,
    output logic [1:0]          o_phase,
    output logic [2:0]          o_last_reason,
    output logic                o_run_truncated
);
    import shd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic       r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [2:0] r_reason, n_reason;
    logic       r_done, n_done;
    logic       r_acc, n_acc;
    logic       r_trunc, n_trunc;
    logic       accept;
    t_cmd       cmd;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_reason = r_reason;
        n_done   = 1'b0;
        n_acc    = 1'b0;
        n_trunc  = 1'b0;
        cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done = 1'b1;
                    case (i_req_type)
                        REQ_BEGIN: begin
                            if (r_phase == PH_IDLE) begin
                                cmd.clear = 1'b1;
                                cmd.store = 1'b1;
                                n_phase   = PH_CAPT;
                                n_acc     = 1'b1;
                            end
                        end
                        REQ_APPEND: begin
                            if (r_phase inside {PH_CAPT, PH_HELD}) begin
                                // result comes when the walk finishes
                                cmd.store = 1'b1;
                                cmd.walk  = 1'b1;
                                n_done    = 1'b0;
                                n_state   = S_WALK;
                            end
                        end
                        REQ_REPLAY: begin
                            if (r_phase == PH_HELD) begin
                                n_phase = PH_REPLAY;
                                n_acc   = 1'b1;
                            end
                        end
                        REQ_FINISH: begin
                            cmd.clear = 1'b1;
                            n_phase   = PH_IDLE;
                            n_acc     = 1'b1;
                        end
                        REQ_INTERRUPT: begin
                            cmd.clear = 1'b1;
                            n_reason  = i_interrupt_reason;
                            n_phase   = PH_IDLE;
                            n_acc     = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_phase = i_stat.held ? PH_HELD : PH_CAPT;
                    n_done  = 1'b1;
                    n_acc   = 1'b1;
                    n_trunc = i_stat.trunc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_reason <= '0;
            r_done   <= 1'b0;
            r_acc    <= 1'b0;
            r_trunc  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_reason <= n_reason;
            r_done   <= n_done;
            r_acc    <= n_acc;
            r_trunc  <= n_trunc;
        end
    end

    assign o_cmd           = cmd;
    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_accepted      = r_acc;
    assign o_phase         = r_phase;
    assign o_last_reason   = r_reason;
    assign o_run_truncated = r_trunc;

endmodule

// ===== rtl/shd_datapath.sv =====
// shd_datapath: configuration registers, sample ring memory, ring pointers and
// the pipelined drift walk (read, square, compare). Depends on shd_pkg.
module shd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [shd_pkg::CFGW-1:0]    i_cfg_wdata,
    input  logic signed [shd_pkg::XW-1:0] i_pos_x,
    input  logic signed [shd_pkg::XW-1:0] i_pos_y,
    input  logic [shd_pkg::TW-1:0]      i_timestamp_us,
    input  shd_pkg::t_cmd               i_cmd,
    output shd_pkg::t_stat              o_stat
);
    import shd_pkg::*;

    localparam int RW = TW + 2 * XW;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        ring_inc = (a == AW'(MAX_SAMPLES - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        ring_dec = (a == '0) ? AW'(MAX_SAMPLES - 1) : a - AW'(1);
    endfunction

    // configuration
    logic [DW-1:0] r_drift;
    logic [HW-1:0] r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift <= DRIFT_RESET;
            r_hold  <= HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DRIFT_LIMIT: r_drift <= i_cfg_wdata[DW-1:0];
                REG_HOLD_US:     r_hold  <= i_cfg_wdata[HW-1:0];
                default: begin
                end
            endcase
        end
    end

    // ring pointers
    logic [AW-1:0] r_wp, n_wp, base_wp;
    logic [CW-1:0] r_count, n_count, base_count;
    logic          r_wrapped, n_wrapped, base_wrapped;

    always_comb begin
        base_wp      = i_cmd.clear ? '0 : r_wp;
        base_count   = i_cmd.clear ? '0 : r_count;
        base_wrapped = i_cmd.clear ? 1'b0 : r_wrapped;
        n_wp         = base_wp;
        n_count      = base_count;
        n_wrapped    = base_wrapped;
        if (i_cmd.store) begin
            n_wp = ring_inc(base_wp);
            if (base_count < CW'(MAX_SAMPLES)) begin
                n_count = base_count + CW'(1);
            end else begin
                n_wrapped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_count   <= '0;
            r_wrapped <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_count   <= n_count;
            r_wrapped <= n_wrapped;
        end
    end

    // walk issue stage
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_iss_addr;
    logic          r_v1, r_v2, r_stop;
    logic          issue;

    assign issue = (r_left != '0) && !r_stop;

    // sample memory, registered read
    logic [RW-1:0] mem [MAX_SAMPLES];
    logic [RW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[base_wp] <= {i_timestamp_us, i_pos_y, i_pos_x};
        end
        r_rd <= mem[r_iss_addr];
    end

    // newest sample and walk limits
    logic signed [XW-1:0] r_new_x, r_new_y;
    logic [TW-1:0]        r_now;
    logic [2*DW-1:0]      r_lim2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_new_x <= i_pos_x;
            r_new_y <= i_pos_y;
            r_now   <= i_timestamp_us;
            r_lim2  <= r_drift * r_drift;
        end
    end

    // square stage
    logic signed [XW:0]     dx, dy;
    logic signed [2*XW+1:0] sqx_full, sqy_full;
    logic [2*XW:0]          r_sqx, r_sqy;
    logic [TW-1:0]          r_t2;
    logic [2*XW+1:0]        d2;

    assign dx = $signed({r_rd[XW-1], r_rd[XW-1:0]}) - $signed({r_new_x[XW-1], r_new_x});
    assign dy = $signed({r_rd[2*XW-1], r_rd[2*XW-1:XW]})
              - $signed({r_new_y[XW-1], r_new_y});
    assign sqx_full = dx * dx;
    assign sqy_full = dy * dy;
    assign d2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        r_sqx <= sqx_full[2*XW:0];
        r_sqy <= sqy_full[2*XW:0];
        r_t2  <= r_rd[RW-1:2*XW];
    end

    // walk control and compare stage
    logic [TW-1:0] r_first_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_iss_addr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_stop     <= 1'b0;
        end else if (i_cmd.walk) begin
            // walk covers every retained sample older than the new one
            r_left     <= (r_count == CW'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES - 1) : r_count;
            r_iss_addr <= ring_dec(r_wp);
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_stop     <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) begin
                r_left     <= r_left - CW'(1);
                r_iss_addr <= ring_dec(r_iss_addr);
            end
            if (r_v2 && !r_stop && (d2 > {2'b0, r_lim2})) begin
                r_stop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_first_t <= i_timestamp_us;
        end else if (r_v2 && !r_stop && (d2 <= {2'b0, r_lim2})) begin
            r_first_t <= r_t2;
        end
    end

    // signed time difference against hold duration
    logic [TW:0] tdiff;
    assign tdiff = {1'b0, r_now} - {1'b0, r_first_t};

    assign o_stat.walk_done = r_stop || ((r_left == '0) && !r_v1 && !r_v2);
    assign o_stat.held      = !tdiff[TW] && (tdiff[TW-1:0] >= {{(TW-HW){1'b0}}, r_hold});
    assign o_stat.trunc     = !r_stop && r_wrapped;

endmodule

// ===== rtl/shd_checker.sv =====
// shd_checker: port-level assertions for stroke_hold_detector, bound to the
// top level below. Depends on shd_pkg.
module shd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic [2:0] i_req_type,
    input logic       o_done,
    input logic       o_accepted,
    input logic [1:0] o_phase,
    input logic       o_run_truncated
);
    import shd_pkg::*;

    // a result never shows while a walk is still running
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // every taken transaction either answers next cycle or starts a walk
    a_take_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_done || o_busy))
        else $error("taken transaction neither answered nor walking");

    // only an accepted append can start a walk
    a_busy_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_req_type == REQ_APPEND))
        else $error("walk started by a non-append transaction");

    // during a walk the phase stays capturing or held
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (o_phase == PH_CAPT || o_phase == PH_HELD))
        else $error("bad phase during walk");

    a_trunc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_truncated |-> (o_done && o_accepted && o_phase != PH_IDLE))
        else $error("truncation flag outside an accepted append result");

endmodule

bind stroke_hold_detector shd_checker u_shd_checker (.*);
